@@ rtl/assert_macros.svh @@
// Assertion macros shared by the price level book checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, off while reset is asserted.
`define PLBU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Property that must hold whenever a result is offered.
`define PLBU_ASSERT_OUT(lbl, prop, msg) \
  `PLBU_ASSERT(lbl, out_valid_o |-> (prop), msg)

`endif

@@ rtl/plbu_pkg.sv @@
// Shared types, constants and codes of the price level book update block.
package plbu_pkg;

  localparam int unsigned BOOK_LEVELS    = 256;
  localparam int unsigned MESSAGE_LEVELS = 64;

  localparam int unsigned VAL_W     = 63;
  localparam int unsigned ID_W      = 64;
  localparam int unsigned SEQ_W     = 64;
  localparam int unsigned STAT_W    = 3;
  localparam int unsigned OCNT_W    = 9;
  localparam int unsigned CFG_IDX_W = 8;

  localparam int unsigned LVL_W     = $clog2(BOOK_LEVELS);
  localparam int unsigned CNT_W     = $clog2(BOOK_LEVELS + 1);
  localparam int unsigned BADDR_W   = LVL_W + 2;
  localparam int unsigned PIDX_W    = $clog2(MESSAGE_LEVELS);
  localparam int unsigned PCNT_W    = $clog2(MESSAGE_LEVELS + 1);
  localparam int unsigned BIT_CNT_W = $clog2(VAL_W + 1);

  localparam logic [VAL_W-1:0]     MIN_SCALED = VAL_W'(100);
  localparam logic [CFG_IDX_W-1:0] CFG_TICK   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_STEP   = CFG_IDX_W'(1);

  localparam logic OP_SNAPSHOT = 1'b0;
  localparam logic OP_DIFF     = 1'b1;
  localparam logic SIDE_BID    = 1'b0;
  localparam logic SIDE_ASK    = 1'b1;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK, STAT_PRICE_LOW, STAT_QTY_LOW, STAT_OFF_TICK,
    STAT_OFF_STEP, STAT_SEQ_OVF, STAT_SIDE_FULL, STAT_TOO_LONG
  } stat_e;

  typedef struct packed {
    logic             op;
    logic             side;
    logic             level_present;
    logic [VAL_W-1:0] price;
    logic [VAL_W-1:0] qty;
    logic [ID_W-1:0]  update_id;
    logic             last;
  } plbu_item_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic              top_bid_valid;
    logic [VAL_W-1:0]  top_bid_px;
    logic [VAL_W-1:0]  top_bid_qt;
    logic              top_ask_valid;
    logic [VAL_W-1:0]  top_ask_px;
    logic [VAL_W-1:0]  top_ask_qt;
    logic              crossed;
    logic [OCNT_W-1:0] bid_depth;
    logic [OCNT_W-1:0] ask_depth;
    logic [SEQ_W-1:0]  sequence_res;
  } plbu_res_t;

  typedef struct packed {
    logic [VAL_W-1:0] price;
    logic [VAL_W-1:0] qty;
  } book_ent_t;

  typedef struct packed {
    logic             side;
    logic [VAL_W-1:0] price;
    logic [VAL_W-1:0] qty;
  } pend_ent_t;

  // One datapath operation per cycle, issued by the controller.
  typedef enum logic [4:0] {
    DP_NOP, DP_LOAD, DP_REM_STEP, DP_RECORD,
    DP_ST_PERR, DP_ST_OVF, DP_ST_FULL,
    DP_SNAP_INIT, DP_COPY_INIT, DP_COPY_RD, DP_COPY_WR, DP_COPY_NEXT,
    DP_LVL_RD, DP_LVL_LOAD, DP_SCAN_RD, DP_SCAN_NEXT, DP_SCAN_HIT,
    DP_UPDATE, DP_LVL_NEXT,
    DP_DEL_INIT, DP_DEL_RD, DP_DEL_WR, DP_DEL_DONE,
    DP_INS_INIT, DP_INS_RD, DP_INS_WR, DP_INS_DONE,
    DP_COMMIT, DP_RPT_BID, DP_RPT_ASK, DP_RPT_DONE, DP_EMIT
  } dp_op_e;

  typedef enum logic [4:0] {
    S_IDLE, S_DECODE, S_CHECK, S_ENDITEM,
    S_CPY_RD, S_CPY_WR, S_LVL_RD, S_LVL_LD,
    S_SCAN_RD, S_SCAN_CMP, S_DECIDE,
    S_DEL_RD, S_DEL_WR, S_INS_RD, S_INS_WR,
    S_RPT_BID, S_RPT_ASK, S_RPT_LAT, S_EMIT
  } ctrl_state_e;

  typedef struct packed {
    logic present;
    logic last;
    logic op;
    logic perr_nz;
    logic rem_done;
    logic seq_max;
    logic cs;
    logic cpy_end;
    logic lvl_end;
    logic scan_end;
    logic scan_less;
    logic lvl_zero;
    logic found;
    logic side_full;
    logic del_end;
    logic ins_end;
    logic out_free;
  } dp_status_t;

endpackage

@@ rtl/plbu_ctrl.sv @@
// Controller state machine: sequences item checks, commit walk and report.
module plbu_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  plbu_pkg::dp_status_t st_i,
  output plbu_pkg::dp_op_e    dp_op_o
);
  import plbu_pkg::*;

  ctrl_state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and datapath operation
  always_comb begin
    state_d    = state_q;
    dp_op_o    = DP_NOP;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          dp_op_o = DP_LOAD;
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        state_d = (st_i.present && !st_i.perr_nz) ? S_CHECK : S_ENDITEM;
      end
      S_CHECK: begin
        if (st_i.rem_done) begin
          dp_op_o = DP_RECORD;
          state_d = S_ENDITEM;
        end else begin
          dp_op_o = DP_REM_STEP;
        end
      end
      S_ENDITEM: begin
        if (!st_i.last) begin
          state_d = S_IDLE;
        end else if (st_i.perr_nz) begin
          dp_op_o = DP_ST_PERR;
          state_d = S_RPT_BID;
        end else if (st_i.op == OP_DIFF && st_i.seq_max) begin
          dp_op_o = DP_ST_OVF;
          state_d = S_RPT_BID;
        end else if (st_i.op == OP_SNAPSHOT) begin
          dp_op_o = DP_SNAP_INIT;
          state_d = S_LVL_RD;
        end else begin
          dp_op_o = DP_COPY_INIT;
          state_d = S_CPY_RD;
        end
      end
      // diff: copy the live tables into the work bank
      S_CPY_RD: begin
        if (st_i.cpy_end) begin
          if (st_i.cs) begin
            state_d = S_LVL_RD;
          end else begin
            dp_op_o = DP_COPY_NEXT;
          end
        end else begin
          dp_op_o = DP_COPY_RD;
          state_d = S_CPY_WR;
        end
      end
      S_CPY_WR: begin
        dp_op_o = DP_COPY_WR;
        state_d = S_CPY_RD;
      end
      // walk the buffered levels
      S_LVL_RD: begin
        if (st_i.lvl_end) begin
          dp_op_o = DP_COMMIT;
          state_d = S_RPT_BID;
        end else begin
          dp_op_o = DP_LVL_RD;
          state_d = S_LVL_LD;
        end
      end
      S_LVL_LD: begin
        dp_op_o = DP_LVL_LOAD;
        state_d = S_SCAN_RD;
      end
      S_SCAN_RD: begin
        if (st_i.scan_end) begin
          state_d = S_DECIDE;
        end else begin
          dp_op_o = DP_SCAN_RD;
          state_d = S_SCAN_CMP;
        end
      end
      S_SCAN_CMP: begin
        if (st_i.scan_less) begin
          dp_op_o = DP_SCAN_NEXT;
          state_d = S_SCAN_RD;
        end else begin
          dp_op_o = DP_SCAN_HIT;
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (st_i.lvl_zero) begin
          if (st_i.op == OP_SNAPSHOT || !st_i.found) begin
            dp_op_o = DP_LVL_NEXT;
            state_d = S_LVL_RD;
          end else begin
            dp_op_o = DP_DEL_INIT;
            state_d = S_DEL_RD;
          end
        end else if (st_i.found) begin
          dp_op_o = DP_UPDATE;
          state_d = S_LVL_RD;
        end else if (st_i.side_full) begin
          dp_op_o = DP_ST_FULL;
          state_d = S_RPT_BID;
        end else begin
          dp_op_o = DP_INS_INIT;
          state_d = S_INS_RD;
        end
      end
      S_DEL_RD: begin
        if (st_i.del_end) begin
          dp_op_o = DP_DEL_DONE;
          state_d = S_LVL_RD;
        end else begin
          dp_op_o = DP_DEL_RD;
          state_d = S_DEL_WR;
        end
      end
      S_DEL_WR: begin
        dp_op_o = DP_DEL_WR;
        state_d = S_DEL_RD;
      end
      S_INS_RD: begin
        if (st_i.ins_end) begin
          dp_op_o = DP_INS_DONE;
          state_d = S_LVL_RD;
        end else begin
          dp_op_o = DP_INS_RD;
          state_d = S_INS_WR;
        end
      end
      S_INS_WR: begin
        dp_op_o = DP_INS_WR;
        state_d = S_INS_RD;
      end
      // top of book readout
      S_RPT_BID: begin
        dp_op_o = DP_RPT_BID;
        state_d = S_RPT_ASK;
      end
      S_RPT_ASK: begin
        dp_op_o = DP_RPT_ASK;
        state_d = S_RPT_LAT;
      end
      S_RPT_LAT: begin
        dp_op_o = DP_RPT_DONE;
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (st_i.out_free) begin
          dp_op_o = DP_EMIT;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/plbu_dp.sv @@
// Datapath: config, remainder checks, pending buffer, banked book tables, result.
module plbu_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  input  logic [plbu_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [plbu_pkg::VAL_W-1:0]          cfg_data_i,
  input  plbu_pkg::plbu_item_t                in_item_i,
  input  plbu_pkg::dp_op_e                    dp_op_i,
  output plbu_pkg::dp_status_t                st_o,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output plbu_pkg::plbu_res_t                 out_res_o
);
  import plbu_pkg::*;

  function automatic logic [BADDR_W-1:0] baddr(logic sd, logic bk, logic [LVL_W-1:0] ix);
    return {sd, bk, ix};
  endfunction

  // configuration
  logic [VAL_W-1:0] tick_q, step_q, tdiv, qdiv;

  // item check
  plbu_item_t           item_q;
  logic [VAL_W-1:0]     shp_q, shq_q, remp_q, remq_q, remp_d, remq_d;
  logic [VAL_W:0]       remp_sh, remq_sh;
  logic [BIT_CNT_W-1:0] bcnt_q;
  stat_e                chk, perr_q, res_stat_q;
  logic [PCNT_W-1:0]    pcnt_q, li_q;

  // memories
  pend_ent_t pend_mem [MESSAGE_LEVELS];
  pend_ent_t pend_rd_q;
  logic      p_we;
  book_ent_t book_mem [4*BOOK_LEVELS];
  book_ent_t book_rd_q, b_wdata;
  logic      b_we, b_re;
  logic [BADDR_W-1:0] b_waddr, b_raddr;

  // commit walk
  logic [1:0]       bank_q;
  logic [CNT_W-1:0] acnt_q [2];
  logic [CNT_W-1:0] wcnt_q [2];
  logic [CNT_W-1:0] j_q, k_q, jp1, jm1, wcnt_s, bid_top;
  logic             cs_q, found_q, s;
  pend_ent_t        lvl_q;
  logic [SEQ_W-1:0] seq_q;
  book_ent_t        bid_ent_q, ask_ent_q;
  logic             out_valid_q, bv, av;
  plbu_res_t        out_res_q, res_d;

  assign tdiv = (tick_q == '0) ? VAL_W'(1) : tick_q;
  assign qdiv = (step_q == '0) ? VAL_W'(1) : step_q;

  // one restoring remainder step for price and qty
  assign remp_sh = {remp_q, shp_q[VAL_W-1]};
  assign remq_sh = {remq_q, shq_q[VAL_W-1]};
  assign remp_d  = (remp_sh >= {1'b0, tdiv}) ? VAL_W'(remp_sh - {1'b0, tdiv})
                                              : VAL_W'(remp_sh);
  assign remq_d  = (remq_sh >= {1'b0, qdiv}) ? VAL_W'(remq_sh - {1'b0, qdiv})
                                              : VAL_W'(remq_sh);

  // level check, valid once all remainder steps are done
  always_comb begin
    if (item_q.price < MIN_SCALED) begin
      chk = STAT_PRICE_LOW;
    end else if (item_q.qty != '0 && item_q.qty < MIN_SCALED) begin
      chk = STAT_QTY_LOW;
    end else if (remp_q != '0) begin
      chk = STAT_OFF_TICK;
    end else if (remq_q != '0) begin
      chk = STAT_OFF_STEP;
    end else if (pcnt_q >= PCNT_W'(MESSAGE_LEVELS)) begin
      chk = STAT_TOO_LONG;
    end else begin
      chk = STAT_OK;
    end
  end

  assign p_we    = (dp_op_i == DP_RECORD) && (perr_q == STAT_OK) && (chk == STAT_OK);
  assign s       = lvl_q.side;
  assign wcnt_s  = wcnt_q[s];
  assign jp1     = CNT_W'(j_q + 1'b1);
  assign jm1     = CNT_W'(j_q - 1'b1);
  assign bid_top = CNT_W'(acnt_q[0] - 1'b1);

  // book memory port control
  always_comb begin
    b_we    = 1'b0;
    b_re    = 1'b0;
    b_waddr = baddr(s, ~bank_q[s], j_q[LVL_W-1:0]);
    b_raddr = baddr(s, ~bank_q[s], k_q[LVL_W-1:0]);
    b_wdata = book_rd_q;
    case (dp_op_i)
      DP_COPY_RD: begin
        b_re    = 1'b1;
        b_raddr = baddr(cs_q, bank_q[cs_q], j_q[LVL_W-1:0]);
      end
      DP_COPY_WR: begin
        b_we    = 1'b1;
        b_waddr = baddr(cs_q, ~bank_q[cs_q], j_q[LVL_W-1:0]);
      end
      DP_SCAN_RD: begin
        b_re = 1'b1;
      end
      DP_UPDATE, DP_INS_DONE: begin
        b_we    = 1'b1;
        b_waddr = baddr(s, ~bank_q[s], k_q[LVL_W-1:0]);
        b_wdata = '{price: lvl_q.price, qty: lvl_q.qty};
      end
      DP_DEL_RD: begin
        b_re    = 1'b1;
        b_raddr = baddr(s, ~bank_q[s], jp1[LVL_W-1:0]);
      end
      DP_INS_RD: begin
        b_re    = 1'b1;
        b_raddr = baddr(s, ~bank_q[s], jm1[LVL_W-1:0]);
      end
      DP_DEL_WR, DP_INS_WR: begin
        b_we = 1'b1;
      end
      DP_RPT_BID: begin
        b_re    = 1'b1;
        b_raddr = baddr(SIDE_BID, bank_q[0], bid_top[LVL_W-1:0]);
      end
      DP_RPT_ASK: begin
        b_re    = 1'b1;
        b_raddr = baddr(SIDE_ASK, bank_q[1], '0);
      end
      default: begin
      end
    endcase
  end

  // memories
  always_ff @(posedge clk_i) begin
    if (b_we) begin
      book_mem[b_waddr] <= b_wdata;
    end
    if (b_re) begin
      book_rd_q <= book_mem[b_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (p_we) begin
      pend_mem[pcnt_q[PIDX_W-1:0]] <= '{side: item_q.side, price: item_q.price,
                                         qty: item_q.qty};
    end
    if (dp_op_i == DP_LVL_RD) begin
      pend_rd_q <= pend_mem[li_q[PIDX_W-1:0]];
    end
  end

  // result assembly
  assign bv = (acnt_q[0] != '0);
  assign av = (acnt_q[1] != '0);
  always_comb begin
    res_d.status        = res_stat_q;
    res_d.top_bid_valid = bv;
    res_d.top_bid_px    = bv ? bid_ent_q.price : '0;
    res_d.top_bid_qt    = bv ? bid_ent_q.qty : '0;
    res_d.top_ask_valid = av;
    res_d.top_ask_px    = av ? ask_ent_q.price : '0;
    res_d.top_ask_qt    = av ? ask_ent_q.qty : '0;
    res_d.crossed       = bv && av && (bid_ent_q.price >= ask_ent_q.price);
    res_d.bid_depth     = OCNT_W'(acnt_q[0]);
    res_d.ask_depth     = OCNT_W'(acnt_q[1]);
    res_d.sequence_res  = seq_q;
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    case (dp_op_i)
      DP_LOAD: begin
        item_q <= in_item_i;
        shp_q  <= in_item_i.price;
        shq_q  <= in_item_i.qty;
        remp_q <= '0;
        remq_q <= '0;
      end
      DP_REM_STEP: begin
        shp_q  <= {shp_q[VAL_W-2:0], 1'b0};
        shq_q  <= {shq_q[VAL_W-2:0], 1'b0};
        remp_q <= remp_d;
        remq_q <= remq_d;
      end
      DP_LVL_LOAD: lvl_q     <= pend_rd_q;
      DP_RPT_ASK:  bid_ent_q <= book_rd_q;
      DP_RPT_DONE: ask_ent_q <= book_rd_q;
      DP_EMIT:     out_res_q <= res_d;
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q      <= VAL_W'(1);
      step_q      <= VAL_W'(1);
      bcnt_q      <= '0;
      perr_q      <= STAT_OK;
      res_stat_q  <= STAT_OK;
      pcnt_q      <= '0;
      li_q        <= '0;
      bank_q      <= '0;
      acnt_q[0]   <= '0;
      acnt_q[1]   <= '0;
      wcnt_q[0]   <= '0;
      wcnt_q[1]   <= '0;
      j_q         <= '0;
      k_q         <= '0;
      cs_q        <= 1'b0;
      found_q     <= 1'b0;
      seq_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_TICK: tick_q <= cfg_data_i;
          CFG_STEP: step_q <= cfg_data_i;
          default: begin
          end
        endcase
      end
      // a new result reloads the register in the cycle the old one leaves
      if (out_valid_q && out_ready_i && dp_op_i != DP_EMIT) begin
        out_valid_q <= 1'b0;
      end
      case (dp_op_i)
        DP_LOAD:     bcnt_q <= BIT_CNT_W'(VAL_W);
        DP_REM_STEP: bcnt_q <= BIT_CNT_W'(bcnt_q - 1'b1);
        DP_RECORD: begin
          if (perr_q == STAT_OK) begin
            if (chk != STAT_OK) begin
              perr_q <= chk;
            end else begin
              pcnt_q <= PCNT_W'(pcnt_q + 1'b1);
            end
          end
        end
        DP_ST_PERR: res_stat_q <= perr_q;
        DP_ST_OVF:  res_stat_q <= STAT_SEQ_OVF;
        DP_ST_FULL: res_stat_q <= STAT_SIDE_FULL;
        DP_SNAP_INIT: begin
          wcnt_q[0] <= '0;
          wcnt_q[1] <= '0;
        end
        DP_COPY_INIT: begin
          cs_q      <= 1'b0;
          j_q       <= '0;
          wcnt_q[0] <= acnt_q[0];
          wcnt_q[1] <= acnt_q[1];
        end
        DP_COPY_WR: j_q <= jp1;
        DP_COPY_NEXT: begin
          cs_q <= 1'b1;
          j_q  <= '0;
        end
        DP_LVL_LOAD: begin
          k_q     <= '0;
          found_q <= 1'b0;
        end
        DP_SCAN_NEXT: k_q     <= CNT_W'(k_q + 1'b1);
        DP_SCAN_HIT:  found_q <= (book_rd_q.price == lvl_q.price);
        DP_UPDATE, DP_LVL_NEXT: li_q <= PCNT_W'(li_q + 1'b1);
        DP_DEL_INIT: j_q <= k_q;
        DP_DEL_WR:   j_q <= jp1;
        DP_DEL_DONE: begin
          wcnt_q[s] <= CNT_W'(wcnt_s - 1'b1);
          li_q      <= PCNT_W'(li_q + 1'b1);
        end
        DP_INS_INIT: j_q <= wcnt_s;
        DP_INS_WR:   j_q <= jm1;
        DP_INS_DONE: begin
          wcnt_q[s] <= CNT_W'(wcnt_s + 1'b1);
          li_q      <= PCNT_W'(li_q + 1'b1);
        end
        // work bank becomes live
        DP_COMMIT: begin
          bank_q     <= ~bank_q;
          acnt_q[0]  <= wcnt_q[0];
          acnt_q[1]  <= wcnt_q[1];
          seq_q      <= (item_q.op == OP_SNAPSHOT) ? '0 : SEQ_W'(seq_q + 1'b1);
          res_stat_q <= STAT_OK;
        end
        DP_EMIT: begin
          out_valid_q <= 1'b1;
          pcnt_q      <= '0;
          li_q        <= '0;
          perr_q      <= STAT_OK;
        end
        default: begin
        end
      endcase
    end
  end

  // status to controller
  always_comb begin
    st_o.present   = item_q.level_present;
    st_o.last      = item_q.last;
    st_o.op        = item_q.op;
    st_o.perr_nz   = (perr_q != STAT_OK);
    st_o.rem_done  = (bcnt_q == '0);
    st_o.seq_max   = &seq_q;
    st_o.cs        = cs_q;
    st_o.cpy_end   = (j_q == acnt_q[cs_q]);
    st_o.lvl_end   = (li_q == pcnt_q);
    st_o.scan_end  = (k_q == wcnt_s);
    st_o.scan_less = (book_rd_q.price < lvl_q.price);
    st_o.lvl_zero  = (lvl_q.qty == '0);
    st_o.found     = found_q;
    st_o.side_full = (wcnt_s == CNT_W'(BOOK_LEVELS));
    st_o.del_end   = (jp1 == wcnt_s);
    st_o.ins_end   = (j_q == k_q);
    st_o.out_free  = !out_valid_q || out_ready_i;
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_res_q;

endmodule

@@ rtl/price_level_book_update_top.sv @@
// Top level of the price level book update block.
// Keeps sorted bid and ask price level tables, double banked so a failed message leaves the
// book untouched. Items are taken one at a time: each level item runs the 63-step bit-serial
// remainder check against tick size and quantity step (price and quantity run in parallel)
// plus decode, record and return to idle before the next request is taken; an empty marker
// skips the remainder check. On the last item of a message the commit runs, for a diff, a
// copy of every level held into the work bank, then for each buffered level a scan of the
// table entries plus a shift of entries on an insert or erase, and then the top of book
// readout before the result is offered.
// A finished result sits in an output register while the next item is taken. Level counts
// make every table entry at or above the count unused, so no clearing pass runs after reset.
// Configuration writes are taken at any time and must be issued only while the block is idle.
module price_level_book_update_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [plbu_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [plbu_pkg::VAL_W-1:0]      cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  plbu_pkg::plbu_item_t            in_item_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output plbu_pkg::plbu_res_t             out_res_o
);
  import plbu_pkg::*;

  dp_op_e     dp_op;
  dp_status_t dp_st;

  assign cfg_ready_o = 1'b1;

  plbu_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .st_i       (dp_st),
    .dp_op_o    (dp_op)
  );

  plbu_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_item_i   (in_item_i),
    .dp_op_i     (dp_op),
    .st_o        (dp_st),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_res_o   (out_res_o)
  );

endmodule

@@ rtl/plbu_checker.sv @@
// Port level checker for the price level book update block, with its bind.
`include "assert_macros.svh"

module plbu_props (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input plbu_pkg::plbu_res_t out_res_o
);

  // a stalled result holds
  `PLBU_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_res_o), "result changed while stalled")

  // one request at a time: a taken item closes the input
  `PLBU_ASSERT(a_in_single, in_valid_i && in_ready_o |=> !in_ready_o, "input ready right after a request")

  // crossed only with both sides present
  `PLBU_ASSERT_OUT(a_crossed, !out_res_o.crossed || (out_res_o.top_bid_valid && out_res_o.top_ask_valid), "crossed with a side empty")

  // side presence agrees with level counts
  `PLBU_ASSERT_OUT(a_bid_cnt, out_res_o.top_bid_valid == (out_res_o.bid_depth != 9'd0), "bid valid disagrees with count")
  `PLBU_ASSERT_OUT(a_ask_cnt, out_res_o.top_ask_valid == (out_res_o.ask_depth != 9'd0), "ask valid disagrees with count")

endmodule

bind price_level_book_update_top plbu_props u_plbu_props (.*);
